/* sv/cfsa_pkg.sv */
// Shared types, constants and helpers for the CAN frame store with aging.
`timescale 1ns / 1ps
package cfsa_pkg;

  // Table geometry
  localparam int ENTRIES = 2048;
  localparam int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

  // Field widths
  localparam int FUNC_W     = 2;
  localparam int ID_W       = 29;
  localparam int LEN_W      = 4;
  localparam int DATA_W     = 64;
  localparam int ENTRY_ID_W = 11;
  localparam int AGE_W      = 3;

  // Function codes
  localparam logic [FUNC_W-1:0] FUNC_STORE = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_TICK  = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_READ  = 2'd2;

  // Reset and limit values
  localparam logic [AGE_W-1:0] AGE_RESET       = 3'd6;
  localparam logic [AGE_W-1:0] STORE_AGE_RESET = 3'd2;
  localparam logic [LEN_W-1:0] LEN_MAX         = 4'd8;

  // One table entry as held in memory
  typedef struct packed {
    logic [AGE_W-1:0]  age;
    logic [LEN_W-1:0]  len;
    logic [DATA_W-1:0] data;
  } entry_t;

  localparam entry_t ENTRY_RESET = '{age: AGE_RESET, len: '0, data: '0};

  // Controller to datapath commands
  typedef struct packed {
    logic store;       // write an incoming frame
    logic read_issue;  // read the entry for an incoming read transaction
    logic sweep_rd;    // aging sweep: read entry at the sweep counter
    logic clear_wr;    // clearing pass: write reset entry at the sweep counter
    logic load_out;    // move read data into the output register
  } cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic cnt_last;    // sweep counter on the last entry
    logic out_free;    // output register can take a result this cycle
  } sts_t;

  // Mask keeping the low len bytes (len saturated to 8 beforehand)
  function automatic logic [DATA_W-1:0] byte_mask(input logic [LEN_W-1:0] len);
    logic [DATA_W-1:0] m;
    for (int b = 0; b < 8; b++) begin
      m[b*8 +: 8] = (len > LEN_W'(b)) ? 8'hFF : 8'h00;
    end
    return m;
  endfunction

endpackage

/* sv/cfsa_channels.sv */
// Valid/ready channel interfaces for frame transactions and read results.
`timescale 1ns / 1ps
interface cfsa_in_if;
  import cfsa_pkg::*;
  logic              valid;
  logic              ready;
  logic [FUNC_W-1:0] func;
  logic [ID_W-1:0]   msg_id;
  logic [LEN_W-1:0]  frame_length;
  logic [DATA_W-1:0] frame_data;

  modport source (output valid, func, msg_id, frame_length, frame_data, input ready);
  modport sink   (input valid, func, msg_id, frame_length, frame_data, output ready);
endinterface

interface cfsa_out_if;
  import cfsa_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [ENTRY_ID_W-1:0] entry_id;
  logic                  fresh;
  logic [LEN_W-1:0]      out_length;
  logic [DATA_W-1:0]     out_data;

  modport source (output valid, entry_id, fresh, out_length, out_data, input ready);
  modport sink   (input valid, entry_id, fresh, out_length, out_data, output ready);
endinterface

/* sv/can_frame_store_with_aging_top.sv */
// Top level of the CAN frame store with aging.
//
// Usage:
//   in_ch  : frame transactions (func, msg_id, frame_length, frame_data).
//            func 0 stores a frame, 1 ages every entry, 2 reads an entry.
//   out_ch : one result per read (entry_id, fresh, out_length, out_data).
//   cfg_we / cfg_wdata : writes store_age, the age given to stored frames.
// Timing:
//   Store: the next transaction can be taken in the following cycle.
//   Read: the memory read is registered, and the result moves into the
//   output register once that register is free. Age tick: the accepting
//   cycle, then ENTRIES sweep reads with each write-back in the cycle after
//   its read, and a final state for the last write-back.
// Reset: a clearing pass writes all ENTRIES (2048) entries, one per cycle,
//   to zero data/length and age six; in_ch.ready stays low meanwhile.
// Stall: a result held in the output register does not block stores or
//   ticks; a following read waits in the controller until out_ch.ready
//   frees the output register.
`timescale 1ns / 1ps
module can_frame_store_with_aging_top (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      cfg_we,
  input  logic [cfsa_pkg::AGE_W-1:0] cfg_wdata,
  cfsa_in_if.sink                   in_ch,
  cfsa_out_if.source                out_ch
);
  import cfsa_pkg::*;

  cmd_t cmd;
  sts_t sts;

  // Controller
  cfsa_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_func  (in_ch.func),
    .in_ready (in_ch.ready),
    .cmd      (cmd),
    .sts      (sts)
  );

  // Datapath
  cfsa_dp u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_we       (cfg_we),
    .cfg_wdata    (cfg_wdata),
    .msg_id       (in_ch.msg_id),
    .frame_length (in_ch.frame_length),
    .frame_data   (in_ch.frame_data),
    .cmd          (cmd),
    .sts          (sts),
    .out_valid    (out_ch.valid),
    .out_ready    (out_ch.ready),
    .entry_id     (out_ch.entry_id),
    .fresh        (out_ch.fresh),
    .out_length   (out_ch.out_length),
    .out_data     (out_ch.out_data)
  );

endmodule

/* sv/cfsa_ctrl.sv */
// Controller state machine: clearing pass, transaction dispatch, aging sweep.
`timescale 1ns / 1ps
module cfsa_ctrl (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  input  logic [cfsa_pkg::FUNC_W-1:0] in_func,
  output logic                       in_ready,
  output cfsa_pkg::cmd_t             cmd,
  input  cfsa_pkg::sts_t             sts
);
  import cfsa_pkg::*;

  typedef enum logic [4:0] {
    S_CLEAR    = 5'b00001,
    S_IDLE     = 5'b00010,
    S_READ     = 5'b00100,
    S_TICK     = 5'b01000,
    S_TICK_END = 5'b10000
  } state_t;

  state_t state_r, state_nxt;

  // Next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    case (state_r)
      S_CLEAR: begin
        cmd.clear_wr = 1'b1;
        if (sts.cnt_last) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          case (in_func)
            FUNC_STORE: cmd.store = 1'b1;
            FUNC_TICK:  state_nxt = S_TICK;
            FUNC_READ: begin
              cmd.read_issue = 1'b1;
              state_nxt      = S_READ;
            end
            default: ;  // unused code, dropped
          endcase
        end
      end
      S_READ: begin
        if (sts.out_free) begin
          cmd.load_out = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      S_TICK: begin
        cmd.sweep_rd = 1'b1;
        if (sts.cnt_last) state_nxt = S_TICK_END;
      end
      S_TICK_END: begin
        // last write-back of the sweep happens in this cycle
        state_nxt = S_IDLE;
      end
      default: state_nxt = S_CLEAR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

/* sv/cfsa_dp.sv */
// Datapath: entry memory, sweep counter, store_age register, output register.
`timescale 1ns / 1ps
module cfsa_dp (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [cfsa_pkg::AGE_W-1:0]      cfg_wdata,
  input  logic [cfsa_pkg::ID_W-1:0]       msg_id,
  input  logic [cfsa_pkg::LEN_W-1:0]      frame_length,
  input  logic [cfsa_pkg::DATA_W-1:0]     frame_data,
  input  cfsa_pkg::cmd_t                 cmd,
  output cfsa_pkg::sts_t                 sts,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [cfsa_pkg::ENTRY_ID_W-1:0] entry_id,
  output logic                           fresh,
  output logic [cfsa_pkg::LEN_W-1:0]      out_length,
  output logic [cfsa_pkg::DATA_W-1:0]     out_data
);
  import cfsa_pkg::*;

  entry_t mem [ENTRIES];

  logic [AGE_W-1:0]      store_age_r;
  logic [IDX_W-1:0]      cnt_r, cnt_nxt;
  logic                  wb_vld_r;
  logic [IDX_W-1:0]      wb_addr_r;
  entry_t                rdata_r;
  logic [IDX_W-1:0]      entry_r;
  logic                  out_valid_r;
  logic [ENTRY_ID_W-1:0] entry_id_r;
  logic                  fresh_r;
  logic [LEN_W-1:0]      out_length_r;
  logic [DATA_W-1:0]     out_data_r;

  logic                  in_range;
  logic [IDX_W-1:0]      in_idx;
  logic [IDX_W-1:0]      rd_addr;
  logic [LEN_W-1:0]      len_sat;
  entry_t                new_entry;
  entry_t                aged;
  logic                  rd_fresh;

  // Index decode: out-of-table ids map to entry 0 (reads) or are dropped (stores)
  assign in_range = (msg_id < ID_W'(ENTRIES));
  assign in_idx   = in_range ? msg_id[IDX_W-1:0] : '0;
  assign rd_addr  = cmd.sweep_rd ? cnt_r : in_idx;

  // New entry: data masked at store time so reads need no mask
  assign len_sat         = (frame_length > LEN_MAX) ? LEN_MAX : frame_length;
  assign new_entry.age   = store_age_r;
  assign new_entry.len   = len_sat;
  assign new_entry.data  = frame_data & byte_mask(len_sat);

  // Aged copy for the sweep write-back
  always_comb begin
    aged = rdata_r;
    if (rdata_r.age != '0) aged.age = rdata_r.age - AGE_W'(1);
  end

  // Sweep counter, shared by the clearing pass and the aging sweep
  assign sts.cnt_last = (cnt_r == IDX_W'(ENTRIES - 1));
  always_comb begin
    cnt_nxt = cnt_r;
    if (cmd.clear_wr || cmd.sweep_rd) cnt_nxt = sts.cnt_last ? '0 : cnt_r + IDX_W'(1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r       <= '0;
      wb_vld_r    <= 1'b0;
      store_age_r <= STORE_AGE_RESET;
    end else begin
      cnt_r    <= cnt_nxt;
      wb_vld_r <= cmd.sweep_rd;
      if (cfg_we) store_age_r <= cfg_wdata;
    end
  end

  // Entry memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (cmd.clear_wr) begin
      mem[cnt_r] <= ENTRY_RESET;
    end else if (wb_vld_r) begin
      mem[wb_addr_r] <= aged;
    end else if (cmd.store && in_range) begin
      mem[in_idx] <= new_entry;
    end
    if (cmd.read_issue || cmd.sweep_rd) rdata_r <= mem[rd_addr];
  end

  // Sweep write-back address and read entry capture
  always_ff @(posedge clk) begin
    if (cmd.sweep_rd)   wb_addr_r <= cnt_r;
    if (cmd.read_issue) entry_r   <= in_idx;
  end

  // Output register
  assign rd_fresh     = (rdata_r.age != '0);
  assign sts.out_free = !out_valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      entry_id_r   <= ENTRY_ID_W'(entry_r);
      fresh_r      <= rd_fresh;
      out_length_r <= rd_fresh ? rdata_r.len : '0;
      out_data_r   <= rd_fresh ? rdata_r.data : '0;
    end
  end

  assign out_valid  = out_valid_r;
  assign entry_id   = entry_id_r;
  assign fresh      = fresh_r;
  assign out_length = out_length_r;
  assign out_data   = out_data_r;

endmodule

/* sv/cfsa_checker.sv */
// Port-level checker for the frame store, bound to the top level.
`timescale 1ns / 1ps
module cfsa_checker (
  input logic                           clk,
  input logic                           rst_n,
  input logic                           in_valid,
  input logic                           in_ready,
  input logic [cfsa_pkg::FUNC_W-1:0]     in_func,
  input logic                           out_valid,
  input logic                           fresh,
  input logic [cfsa_pkg::LEN_W-1:0]      out_length,
  input logic [cfsa_pkg::DATA_W-1:0]     out_data
);
  import cfsa_pkg::*;

  // No transaction is taken in the cycle after reset: the clearing pass runs
  a_clear_after_reset: assert property (@(posedge clk) !rst_n |=> !in_ready)
    else $error("input ready during clearing pass");

  // A taken read transaction moves the controller to its read state, where in_ready is low
  a_read_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && in_func == FUNC_READ) |=> !in_ready)
    else $error("input ready right after read transaction");

  // Stores, ticks and unused codes never create a result
  a_no_spurious_result: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && in_func != FUNC_READ && !out_valid) |=> !out_valid)
    else $error("result without a read transaction");

  // Stale results carry zero length and data; lengths never exceed eight
  a_stale_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !fresh) |-> (out_length == '0 && out_data == '0))
    else $error("stale result with nonzero payload");

  a_len_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_length <= LEN_MAX))
    else $error("result length above eight");

endmodule

bind can_frame_store_with_aging_top cfsa_checker u_cfsa_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_valid   (in_ch.valid),
  .in_ready   (in_ch.ready),
  .in_func    (in_ch.func),
  .out_valid  (out_ch.valid),
  .fresh      (out_ch.fresh),
  .out_length (out_ch.out_length),
  .out_data   (out_ch.out_data)
);
